[src/apt_pkg.sv]
package apt_pkg;

  // Default table size
  localparam int ENTRIES_DEF = 16;

  // Operation codes
  localparam logic [2:0] OP_ALLOW     = 3'd0;
  localparam logic [2:0] OP_BLOCK     = 3'd1;
  localparam logic [2:0] OP_CLEAR     = 3'd2;
  localparam logic [2:0] OP_CLEAR_ALL = 3'd3;
  localparam logic [2:0] OP_CHECK     = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Blocked level codes
  localparam logic [1:0] LVL_NONE   = 2'd0;
  localparam logic [1:0] LVL_MEMBER = 2'd1;
  localparam logic [1:0] LVL_OBJECT = 2'd2;

  // Check kind codes
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_EXEC  = 2'd2;

  // Mode bits
  localparam logic [2:0] MODE_R = 3'b001;
  localparam logic [2:0] MODE_W = 3'b010;
  localparam logic [2:0] MODE_X = 3'b100;

  typedef struct packed {
    logic [2:0]  operation;
    logic [63:0] object_id;
    logic        has_key;
    logic [31:0] key_tag;
    logic [2:0]  modes;
    logic [1:0]  check_kind;
  } req_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic       access_allowed;
    logic [1:0] blocked_level;
  } rsp_word_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

  // Decision of one rule for one mode bit
  typedef struct packed {
    logic blk;
    logic alw;
  } dec_t;

  function automatic logic [2:0] kind_to_mode(input logic [1:0] kind);
    logic [2:0] m;
    case (kind)
      KIND_READ:  m = MODE_R;
      KIND_WRITE: m = MODE_W;
      KIND_EXEC:  m = MODE_X;
      default:    m = 3'b000;
    endcase
    return m;
  endfunction

  // Block bit blocks; a non-empty allow mask without the bit blocks;
  // a set allow bit is an explicit allow.
  function automatic dec_t decide(input logic [2:0] allow_m, input logic [2:0] block_m,
                                  input logic [2:0] m);
    dec_t d;
    d.blk = (|(block_m & m)) || ((|allow_m) && !(|(allow_m & m)));
    d.alw = !d.blk && (|(allow_m & m));
    return d;
  endfunction

endpackage

[src/apt_ctrl.sv]
module apt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output apt_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state, state_next;
  logic   rsp_valid_next;

  assign req_ready = (state == S_IDLE);

  // Sequencing: take a word, then execute once the result slot is free
  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.exec   = 1'b0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Result slot occupancy
  assign rsp_valid_next = cmd.exec | (rsp_valid & ~rsp_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

`ifndef ASSERT_OFF
  a_exec_in_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> state == S_EXEC) else $error("execute outside EXEC state");
  a_load_to_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_EXEC) else $error("load did not move to EXEC");
  a_exec_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> rsp_valid) else $error("execute gave no result");
  a_free_slot_exec: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && !rsp_valid) |=> state == S_IDLE)
    else $error("EXEC stalled with a free result slot");
  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state lost its one-hot code");
`endif

endmodule

[src/apt_datapath.sv]
module apt_datapath #(
  parameter int ENTRIES = apt_pkg::ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  apt_pkg::cmd_t      cmd,
  input  apt_pkg::req_word_t req,
  output apt_pkg::rsp_word_t rsp
);

  localparam logic [ENTRIES-1:0] ONE = ENTRIES'(1);

  // Held request word
  apt_pkg::req_word_t cur;

  // Rule table, one lane per entry
  logic [ENTRIES-1:0] valid;
  logic [63:0]        obj_r   [ENTRIES];
  logic [ENTRIES-1:0] has_mem;
  logic [31:0]        tag_r   [ENTRIES];
  logic [2:0]         allow_r [ENTRIES];
  logic [2:0]         block_r [ENTRIES];

  logic [ENTRIES-1:0] key_m, obj_m, key_f, obj_f, free_f;
  logic [ENTRIES-1:0] blk_v, alw_v;
  logic [2:0]         chk_mode;
  logic               key_hit, free_any, upd_en, allow_op;
  logic               mem_blk, mem_alw, obj_blk;
  apt_pkg::dec_t      dec_l [ENTRIES];
  apt_pkg::rsp_word_t res;

  assign chk_mode = apt_pkg::kind_to_mode(cur.check_kind);

  // Per-lane compare and decision
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      key_m[i] = valid[i] && (obj_r[i] == cur.object_id) && (has_mem[i] == cur.has_key)
                 && (!cur.has_key || (tag_r[i] == cur.key_tag));
      obj_m[i] = valid[i] && (obj_r[i] == cur.object_id) && !has_mem[i];
      dec_l[i] = apt_pkg::decide(allow_r[i], block_r[i], chk_mode);
      blk_v[i] = dec_l[i].blk;
      alw_v[i] = dec_l[i].alw;
    end
  end

  // Lowest matching and lowest free lane, one-hot
  assign key_f    = key_m & (~key_m + ONE);
  assign obj_f    = obj_m & (~obj_m + ONE);
  assign free_f   = ~valid & (valid + ONE);
  assign key_hit  = |key_m;
  assign free_any = ~&valid;

  assign allow_op = (cur.operation == apt_pkg::OP_ALLOW);
  assign upd_en   = cmd.exec && (cur.modes != 3'b000)
                    && (cur.operation == apt_pkg::OP_ALLOW
                        || cur.operation == apt_pkg::OP_BLOCK);

  // Check: member rule first, then object rule
  assign mem_blk = cur.has_key && |(key_f & blk_v);
  assign mem_alw = cur.has_key && |(key_f & alw_v);
  assign obj_blk = |(obj_f & blk_v);

  // Result word
  always_comb begin
    res.status         = apt_pkg::ST_OK;
    res.access_allowed = 1'b1;
    res.blocked_level  = apt_pkg::LVL_NONE;
    case (cur.operation)
      apt_pkg::OP_ALLOW, apt_pkg::OP_BLOCK: begin
        if (cur.modes == 3'b000) begin
          res.status = apt_pkg::ST_EMPTY;
        end else if (!key_hit && !free_any) begin
          res.status = apt_pkg::ST_FULL;
        end
      end
      apt_pkg::OP_CHECK: begin
        if (mem_blk) begin
          res.access_allowed = 1'b0;
          res.blocked_level  = apt_pkg::LVL_MEMBER;
        end else if (!mem_alw && obj_blk) begin
          res.access_allowed = 1'b0;
          res.blocked_level  = apt_pkg::LVL_OBJECT;
        end
      end
      default: ;
    endcase
  end

  // Input and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= req;
    end
    if (cmd.exec) begin
      rsp <= res;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.exec) begin
      case (cur.operation)
        apt_pkg::OP_ALLOW, apt_pkg::OP_BLOCK: begin
          if (cur.modes != 3'b000 && !key_hit) begin
            valid <= valid | free_f;
          end
        end
        apt_pkg::OP_CLEAR:     valid <= valid & ~key_f;
        apt_pkg::OP_CLEAR_ALL: valid <= '0;
        default: ;
      endcase
    end
  end

  // Rule contents: merge into a hit, or create in the lowest free lane
  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (upd_en) begin
        if (key_f[i]) begin
          if (allow_op) begin
            allow_r[i] <= allow_r[i] | cur.modes;
          end else begin
            block_r[i] <= block_r[i] | cur.modes;
          end
        end else if (!key_hit && free_f[i]) begin
          obj_r[i]   <= cur.object_id;
          has_mem[i] <= cur.has_key;
          tag_r[i]   <= cur.key_tag;
          allow_r[i] <= allow_op ? cur.modes : 3'b000;
          block_r[i] <= allow_op ? 3'b000 : cur.modes;
        end
      end
    end
  end

endmodule

[src/access_policy_table_core.sv]
// Channel | Direction | Handshake             | Word
// req     | in        | req_valid / req_ready | apt_pkg::req_word_t
// rsp     | out       | rsp_valid / rsp_ready | apt_pkg::rsp_word_t
//
// Each word is first captured in IDLE; EXEC then does the parallel
// lookup over all table lanes, update and result register load.
// A new word is taken in the cycle after execution, so no word is taken
// before the last one has executed; a held result delays execution and so the next word.
// Reset (rst, synchronous) empties the table at once by clearing valid bits.
module access_policy_table_core #(
  parameter int ENTRIES = apt_pkg::ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  apt_pkg::req_word_t req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output apt_pkg::rsp_word_t rsp
);

  apt_pkg::cmd_t cmd;

  apt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd)
  );

  apt_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

endmodule

[tb/tb_access_policy_table_core.sv]
`timescale 1ns / 100ps

module tb_access_policy_table_core;

  localparam int ENT = apt_pkg::ENTRIES_DEF;
  localparam int RANDOM_WORDS = 520;
  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD = 150;
  localparam int DRAIN_CYCLES = 12;

  typedef enum int {V_BLOCK, V_NONE, V_ALLOW} verdict_t;

  // Expectation note travelling with each offered word
  typedef struct {
    bit                 fixed;
    apt_pkg::rsp_word_t want;
  } rsp_note_t;

  typedef struct {
    apt_pkg::req_word_t word;
    bit                 fixed;
    apt_pkg::rsp_word_t want;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_ready;
  apt_pkg::req_word_t req = '0;
  logic               rsp_valid;
  logic               rsp_ready = 1'b0;
  apt_pkg::rsp_word_t rsp;

  access_policy_table_core uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the rule table
  bit          tbl_live [ENT];
  logic [63:0] tbl_obj  [ENT];
  bit          tbl_mem  [ENT];
  logic [31:0] tbl_tag  [ENT];
  logic [2:0]  tbl_allow[ENT];
  logic [2:0]  tbl_block[ENT];

  rsp_note_t          note_q[$];
  apt_pkg::rsp_word_t pending_rsp[$];
  dir_row_t           dir_rows[$];

  int errors = 0;
  int stall_cycles = 0;
  int words_in = 0;
  int rsp_seen = 0;
  int full_seen = 0;
  int member_blk = 0;
  int object_blk = 0;
  int burst_left = 0;
  bit long_hold_done = 1'b0;

  logic [63:0] obj_pool[4];
  logic [31:0] tag_pool[4];

  function automatic int find_rule(input logic [63:0] obj, input bit mem,
                                   input logic [31:0] tag);
    int hit;
    hit = -1;
    for (int i = ENT - 1; i >= 0; i--) begin
      if (tbl_live[i] && tbl_obj[i] == obj && tbl_mem[i] == mem &&
          (!mem || tbl_tag[i] == tag))
        hit = i;
    end
    return hit;
  endfunction

  function automatic verdict_t rule_verdict(input int slot, input logic [2:0] m);
    verdict_t v;
    v = V_NONE;
    if (slot >= 0) begin
      if ((tbl_block[slot] & m) != 3'b000)
        v = V_BLOCK;
      else if (tbl_allow[slot] != 3'b000 && (tbl_allow[slot] & m) == 3'b000)
        v = V_BLOCK;
      else if ((tbl_allow[slot] & m) != 3'b000)
        v = V_ALLOW;
    end
    return v;
  endfunction

  // Applies one word to the shadow table and returns the response it should give
  function automatic apt_pkg::rsp_word_t apply_policy_word(input apt_pkg::req_word_t w);
    apt_pkg::rsp_word_t r;
    int                 slot;
    logic [31:0]        tag;
    logic [2:0]         m;
    verdict_t           v;
    r.status = apt_pkg::ST_OK;
    r.access_allowed = 1'b1;
    r.blocked_level = apt_pkg::LVL_NONE;
    tag = w.has_key ? w.key_tag : 32'h0;
    case (w.operation)
      apt_pkg::OP_ALLOW, apt_pkg::OP_BLOCK: begin
        if (w.modes == 3'b000) begin
          r.status = apt_pkg::ST_EMPTY;
        end else begin
          slot = find_rule(w.object_id, w.has_key, tag);
          if (slot < 0) begin
            for (int i = ENT - 1; i >= 0; i--)
              if (!tbl_live[i]) slot = i;
            if (slot >= 0) begin
              tbl_live[slot] = 1'b1;
              tbl_obj[slot] = w.object_id;
              tbl_mem[slot] = w.has_key;
              tbl_tag[slot] = tag;
              tbl_allow[slot] = 3'b000;
              tbl_block[slot] = 3'b000;
            end
          end
          if (slot < 0)
            r.status = apt_pkg::ST_FULL;
          else if (w.operation == apt_pkg::OP_ALLOW)
            tbl_allow[slot] = tbl_allow[slot] | w.modes;
          else
            tbl_block[slot] = tbl_block[slot] | w.modes;
        end
      end
      apt_pkg::OP_CLEAR: begin
        slot = find_rule(w.object_id, w.has_key, tag);
        if (slot >= 0) tbl_live[slot] = 1'b0;
      end
      apt_pkg::OP_CLEAR_ALL: begin
        for (int i = 0; i < ENT; i++) tbl_live[i] = 1'b0;
      end
      apt_pkg::OP_CHECK: begin
        case (w.check_kind)
          apt_pkg::KIND_READ:  m = apt_pkg::MODE_R;
          apt_pkg::KIND_WRITE: m = apt_pkg::MODE_W;
          apt_pkg::KIND_EXEC:  m = apt_pkg::MODE_X;
          default:             m = 3'b000;
        endcase
        v = V_NONE;
        // member rule first; an explicit allow there ends the check
        if (w.has_key) begin
          v = rule_verdict(find_rule(w.object_id, 1'b1, tag), m);
          if (v == V_BLOCK) begin
            r.access_allowed = 1'b0;
            r.blocked_level = apt_pkg::LVL_MEMBER;
          end
        end
        if (v == V_NONE &&
            rule_verdict(find_rule(w.object_id, 1'b0, 32'h0), m) == V_BLOCK) begin
          r.access_allowed = 1'b0;
          r.blocked_level = apt_pkg::LVL_OBJECT;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic apt_pkg::req_word_t mk_word(input logic [2:0] op,
                                                 input logic [63:0] obj,
                                                 input bit key, input logic [31:0] tag,
                                                 input logic [2:0] modes,
                                                 input logic [1:0] kind);
    apt_pkg::req_word_t w;
    w.operation = op;
    w.object_id = obj;
    w.has_key = key;
    w.key_tag = tag;
    w.modes = modes;
    w.check_kind = kind;
    return w;
  endfunction

  function automatic apt_pkg::rsp_word_t mk_rsp(input logic [1:0] st, input logic alw,
                                                input logic [1:0] lvl);
    apt_pkg::rsp_word_t r;
    r.status = st;
    r.access_allowed = alw;
    r.blocked_level = lvl;
    return r;
  endfunction

  function automatic void add_row(input apt_pkg::req_word_t w, input bit fixed,
                                  input apt_pkg::rsp_word_t want);
    dir_row_t d;
    d.word = w;
    d.fixed = fixed;
    d.want = want;
    dir_rows.push_back(d);
  endfunction

  // Random word over a small pool of keys so that rules get hit again
  function automatic apt_pkg::req_word_t rand_word();
    int          r;
    logic [2:0]  op;
    logic [63:0] obj;
    bit          key;
    logic [31:0] tag;
    r = $urandom_range(0, 99);
    if (r < 28)      op = apt_pkg::OP_ALLOW;
    else if (r < 48) op = apt_pkg::OP_BLOCK;
    else if (r < 56) op = apt_pkg::OP_CLEAR;
    else if (r < 58) op = apt_pkg::OP_CLEAR_ALL;
    else if (r < 96) op = apt_pkg::OP_CHECK;
    else             op = 3'($urandom_range(5, 7));
    obj = ($urandom_range(0, 99) < 88) ? obj_pool[$urandom_range(0, 3)]
                                       : {$urandom(), $urandom()};
    key = 1'($urandom_range(0, 1));
    tag = (key && $urandom_range(0, 99) < 85) ? tag_pool[$urandom_range(0, 3)]
                                              : $urandom();
    return mk_word(op, obj, key, tag, 3'($urandom_range(0, 7)),
                   2'($urandom_range(0, 3)));
  endfunction

  // Offers one word in bursts with random gaps; entered and left at a falling edge
  task automatic send_word(input apt_pkg::req_word_t w, input bit fixed,
                           input apt_pkg::rsp_word_t want);
    rsp_note_t n;
    int        gap;
    n.fixed = fixed;
    n.want = want;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    note_q.push_back(n);
    req <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  task automatic send_random(input apt_pkg::req_word_t w);
    send_word(w, 1'b0, '0);
    words_in++;
  endtask

  // Sampling on the rising edge: prediction on accept, compare on result
  always @(posedge clk) begin : sample
    rsp_note_t          n;
    apt_pkg::rsp_word_t p;
    apt_pkg::rsp_word_t e;
    if (!rst) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (req_valid && req_ready) begin
        p = apply_policy_word(req);
        if (note_q.size() != 0) begin
          n = note_q.pop_front();
          pending_rsp.push_back(n.fixed ? n.want : p);
        end else begin
          pending_rsp.push_back(p);
        end
      end
      if (rsp_valid && rsp_ready) begin
        rsp_seen++;
        if (rsp.status == apt_pkg::ST_FULL) full_seen++;
        if (rsp.blocked_level == apt_pkg::LVL_MEMBER) member_blk++;
        if (rsp.blocked_level == apt_pkg::LVL_OBJECT) object_blk++;
        if (pending_rsp.size() == 0) begin
          $display("%0t: unexpected response word %h", $time, rsp);
          errors++;
        end else begin
          e = pending_rsp.pop_front();
          if (rsp.status !== e.status) begin
            $display("%0t: status expected %0d got %0d", $time, e.status, rsp.status);
            errors++;
          end
          if (rsp.access_allowed !== e.access_allowed) begin
            $display("%0t: access_allowed expected %0d got %0d", $time,
                     e.access_allowed, rsp.access_allowed);
            errors++;
          end
          if (rsp.blocked_level !== e.blocked_level) begin
            $display("%0t: blocked_level expected %0d got %0d", $time,
                     e.blocked_level, rsp.blocked_level);
            errors++;
          end
        end
      end
    end
  end

  // Receiver: stall patterns of its own, and one long hold-off to fill the block
  initial begin : rsp_side
    int mode;
    int run;
    int period;
    while (rst) @(negedge clk);
    forever begin
      if (!long_hold_done && rsp_seen >= 60) begin
        rsp_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      run = $urandom_range(4, 40);
      period = $urandom_range(2, 5);
      for (int c = 0; c < run; c++) begin
        case (mode)
          0: rsp_ready <= 1'b1;
          1: rsp_ready <= ($urandom_range(0, 3) != 0);
          2: rsp_ready <= 1'($urandom_range(0, 1));
          default: rsp_ready <= ((c % period) != 0);
        endcase
        @(negedge clk);
      end
    end
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  // Stimulus
  initial begin : stim
    logic [31:0] base;
    int          len;
    obj_pool[0] = 64'h0;
    obj_pool[1] = {64{1'b1}};
    obj_pool[2] = {$urandom(), $urandom()};
    obj_pool[3] = {$urandom(), $urandom()};
    tag_pool[0] = 32'h0;
    tag_pool[1] = 32'hFFFF_FFFF;
    tag_pool[2] = $urandom();
    tag_pool[3] = $urandom();
    for (int i = 0; i < ENT; i++) tbl_live[i] = 1'b0;

    // directed rows: fixed responses only where they are plain
    add_row(mk_word(apt_pkg::OP_CHECK, 64'h0, 1'b0, 32'h0, 3'b000, apt_pkg::KIND_READ),
            1'b1, mk_rsp(apt_pkg::ST_OK, 1'b1, apt_pkg::LVL_NONE));
    add_row(mk_word(apt_pkg::OP_ALLOW, 64'h0, 1'b0, 32'h0, 3'b000, apt_pkg::KIND_READ),
            1'b1, mk_rsp(apt_pkg::ST_EMPTY, 1'b1, apt_pkg::LVL_NONE));
    add_row(mk_word(apt_pkg::OP_BLOCK, {64{1'b1}}, 1'b1, 32'hFFFF_FFFF, 3'b000,
                    apt_pkg::KIND_EXEC),
            1'b1, mk_rsp(apt_pkg::ST_EMPTY, 1'b1, apt_pkg::LVL_NONE));
    add_row(mk_word(apt_pkg::OP_ALLOW, 64'h0, 1'b0, 32'h0, apt_pkg::MODE_R,
                    apt_pkg::KIND_READ),
            1'b1, mk_rsp(apt_pkg::ST_OK, 1'b1, apt_pkg::LVL_NONE));
    add_row(mk_word(apt_pkg::OP_CHECK, 64'h0, 1'b0, 32'h0, 3'b000, apt_pkg::KIND_WRITE),
            1'b1, mk_rsp(apt_pkg::ST_OK, 1'b0, apt_pkg::LVL_OBJECT));
    add_row(mk_word(apt_pkg::OP_CHECK, 64'h0, 1'b0, 32'h0, 3'b000, apt_pkg::KIND_READ),
            1'b1, mk_rsp(apt_pkg::ST_OK, 1'b1, apt_pkg::LVL_NONE));
    add_row(mk_word(apt_pkg::OP_CHECK, 64'h0, 1'b0, 32'h0, 3'b000, 2'd3),
            1'b1, mk_rsp(apt_pkg::ST_OK, 1'b0, apt_pkg::LVL_OBJECT));
    add_row(mk_word(apt_pkg::OP_ALLOW, 64'h0, 1'b1, 32'h0, apt_pkg::MODE_W,
                    apt_pkg::KIND_READ), 1'b0, '0);
    add_row(mk_word(apt_pkg::OP_CHECK, 64'h0, 1'b1, 32'h0, 3'b000, apt_pkg::KIND_WRITE),
            1'b0, '0);
    add_row(mk_word(apt_pkg::OP_CHECK, 64'h0, 1'b1, 32'h0, 3'b000, apt_pkg::KIND_READ),
            1'b0, '0);
    add_row(mk_word(apt_pkg::OP_BLOCK, {64{1'b1}}, 1'b0, 32'hFFFF_FFFF, apt_pkg::MODE_X,
                    apt_pkg::KIND_READ), 1'b0, '0);
    add_row(mk_word(apt_pkg::OP_CHECK, {64{1'b1}}, 1'b1, 32'h1234_5678, 3'b111,
                    apt_pkg::KIND_EXEC), 1'b0, '0);
    add_row(mk_word(apt_pkg::OP_CHECK, {64{1'b1}}, 1'b1, 32'h1234_5678, 3'b000,
                    apt_pkg::KIND_READ), 1'b0, '0);
    add_row(mk_word(apt_pkg::OP_BLOCK, 64'h0, 1'b1, 32'h0, 3'b111, apt_pkg::KIND_READ),
            1'b0, '0);
    add_row(mk_word(apt_pkg::OP_CHECK, 64'h0, 1'b1, 32'h0, 3'b000, apt_pkg::KIND_WRITE),
            1'b0, '0);
    add_row(mk_word(apt_pkg::OP_CLEAR, 64'h0, 1'b1, 32'h0, 3'b000, apt_pkg::KIND_READ),
            1'b1, mk_rsp(apt_pkg::ST_OK, 1'b1, apt_pkg::LVL_NONE));
    add_row(mk_word(apt_pkg::OP_CLEAR, 64'h5, 1'b0, 32'h0, 3'b000, apt_pkg::KIND_READ),
            1'b1, mk_rsp(apt_pkg::ST_OK, 1'b1, apt_pkg::LVL_NONE));
    add_row(mk_word(apt_pkg::OP_CHECK, 64'h0, 1'b1, 32'h0, 3'b000, apt_pkg::KIND_WRITE),
            1'b0, '0);
    add_row(mk_word(3'd5, 64'h0, 1'b0, 32'h0, apt_pkg::MODE_R, apt_pkg::KIND_READ),
            1'b1, mk_rsp(apt_pkg::ST_OK, 1'b1, apt_pkg::LVL_NONE));
    add_row(mk_word(3'd7, {64{1'b1}}, 1'b1, 32'hFFFF_FFFF, 3'b111, 2'd3),
            1'b1, mk_rsp(apt_pkg::ST_OK, 1'b1, apt_pkg::LVL_NONE));
    add_row(mk_word(apt_pkg::OP_CLEAR_ALL, 64'h0, 1'b0, 32'h0, 3'b000, apt_pkg::KIND_READ),
            1'b1, mk_rsp(apt_pkg::ST_OK, 1'b1, apt_pkg::LVL_NONE));
    add_row(mk_word(apt_pkg::OP_CHECK, 64'h0, 1'b0, 32'h0, 3'b000, apt_pkg::KIND_WRITE),
            1'b1, mk_rsp(apt_pkg::ST_OK, 1'b1, apt_pkg::LVL_NONE));
    add_row(mk_word(apt_pkg::OP_ALLOW, 64'h0, 1'b1, 32'hFFFF_FFFF, 3'b111,
                    apt_pkg::KIND_READ),
            1'b1, mk_rsp(apt_pkg::ST_OK, 1'b1, apt_pkg::LVL_NONE));
    add_row(mk_word(apt_pkg::OP_CHECK, 64'h0, 1'b1, 32'hFFFF_FFFF, 3'b000, 2'd3),
            1'b0, '0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].fixed, dir_rows[i].want);

    // random part: short sequences, some of them filling the table to the brim
    while (words_in < RANDOM_WORDS) begin
      if ($urandom_range(0, 9) == 0) begin
        send_random(mk_word(apt_pkg::OP_CLEAR_ALL, 64'h0, 1'b0, $urandom(), 3'b000,
                            apt_pkg::KIND_READ));
        base = $urandom();
        for (int i = 0; i <= ENT; i++)
          send_random(mk_word($urandom_range(0, 1) ? apt_pkg::OP_ALLOW : apt_pkg::OP_BLOCK,
                              obj_pool[2], 1'b1, base + i, 3'($urandom_range(1, 7)),
                              2'($urandom_range(0, 3))));
        send_random(mk_word(apt_pkg::OP_BLOCK, obj_pool[2], 1'b1, base,
                            3'($urandom_range(1, 7)), apt_pkg::KIND_READ));
        for (int i = 0; i < 4; i++)
          send_random(mk_word(apt_pkg::OP_CHECK, obj_pool[2], 1'b1,
                              base + $urandom_range(0, ENT), 3'b000,
                              2'($urandom_range(0, 3))));
      end else begin
        if ($urandom_range(0, 4) == 0)
          send_random(mk_word(apt_pkg::OP_CLEAR_ALL, obj_pool[0], 1'b0, 32'h0, 3'b000,
                              apt_pkg::KIND_READ));
        len = $urandom_range(6, 30);
        for (int i = 0; i < len; i++) send_random(rand_word());
      end
    end
    req_valid <= 1'b0;

    while (pending_rsp.size() != 0 || note_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d directed and %0d random words; checked %0d responses.",
             dir_rows.size(), words_in, rsp_seen);
    $display("Table-full responses %0d, member-level blocks %0d, object-level blocks %0d.",
             full_seen, member_blk, object_blk);
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

[files.f]
src/apt_pkg.sv
src/apt_ctrl.sv
src/apt_datapath.sv
src/access_policy_table_core.sv
tb/tb_access_policy_table_core.sv
